// ===== design/sprfb_pkg.sv =====
package sprfb_pkg;

  localparam int SCREEN_WIDTH  = 64;
  localparam int SCREEN_HEIGHT = 32;
  localparam int ROW_SPAN      = 8;
  localparam int ROW_IDX_W     = $clog2(SCREEN_HEIGHT);

  typedef logic [SCREEN_WIDTH-1:0] row_word_t;
  typedef logic [ROW_IDX_W-1:0]    row_idx_t;

  typedef enum logic {
    OP_DRAW = 1'b0,
    OP_READ = 1'b1
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] col_x;
    logic [7:0] row_y;
    logic [7:0] sprite_bits;
  } item_t;

  typedef struct packed {
    logic       collision;
    logic [7:0] pixels_read;
  } result_t;

endpackage

// ===== design/sprfb_if.sv =====
interface sprfb_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] col_x;
  logic [7:0] row_y;
  logic [7:0] sprite_bits;

  modport source (output valid, output op, output col_x, output row_y,
                  output sprite_bits, input ready);
  modport sink   (input valid, input op, input col_x, input row_y,
                  input sprite_bits, output ready);
endinterface

interface sprfb_out_if;
  logic       valid;
  logic       ready;
  logic       collision;
  logic [7:0] pixels_read;

  modport source (output valid, output collision, output pixels_read, input ready);
  modport sink   (input valid, input collision, input pixels_read, output ready);
endinterface

// ===== design/sprfb_frame_store.sv =====
module sprfb_frame_store (
  input  logic                clk,
  input  logic                rst,
  input  sprfb_pkg::row_idx_t idx,
  output sprfb_pkg::row_word_t rd_row,
  input  logic                we,
  input  sprfb_pkg::row_word_t wr_row
);

  sprfb_pkg::row_word_t rows [sprfb_pkg::SCREEN_HEIGHT];

  assign rd_row = rows[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < sprfb_pkg::SCREEN_HEIGHT; r++) begin
        rows[r] <= '0;
      end
    end else if (we) begin
      rows[idx] <= wr_row;
    end
  end

endmodule

// ===== design/sprfb_row_unit.sv =====
module sprfb_row_unit (
  input  sprfb_pkg::item_t     item,
  input  sprfb_pkg::row_word_t row,
  output sprfb_pkg::row_word_t row_next,
  output logic                 we,
  output sprfb_pkg::result_t   res
);

  localparam int W = sprfb_pkg::SCREEN_WIDTH;
  localparam int S = sprfb_pkg::ROW_SPAN;

  logic                 on_screen;
  logic [S-1:0]         rev_bits;
  sprfb_pkg::row_word_t mask;
  sprfb_pkg::row_word_t shifted;
  logic [S-1:0]         window;

  assign on_screen = ({1'b0, item.col_x} < 9'(W)) &&
                     ({1'b0, item.row_y} < 9'(sprfb_pkg::SCREEN_HEIGHT));

  // column x+i takes sprite bit 7-i; columns past the edge fall off the shift
  always_comb begin
    for (int i = 0; i < S; i++) begin
      rev_bits[i] = item.sprite_bits[S-1-i];
    end
  end

  assign mask    = {{(W-S){1'b0}}, rev_bits} << item.col_x;
  assign shifted = row >> item.col_x;
  assign window  = shifted[S-1:0];

  always_comb begin
    row_next        = row ^ mask;
    we              = on_screen && (item.op == sprfb_pkg::OP_DRAW);
    res.collision   = we && (|(row & mask));
    res.pixels_read = '0;
    if (on_screen && (item.op == sprfb_pkg::OP_READ)) begin
      for (int i = 0; i < S; i++) begin
        res.pixels_read[S-1-i] = window[i];
      end
    end
  end

endmodule

// ===== design/sprite_row_xor_framebuffer_core.sv =====
// Path: a beat is registered in stage s1, then its result in the output
// register; s1 holds its beat while the output result is not taken.
// Throughput: one item per cycle while the output is taken; the row
// read-modify-write of the register framebuffer completes as an item leaves s1.
// Reset: synchronous; clears every pixel and empties both pipeline stages.
module sprite_row_xor_framebuffer_core (
  input  logic        clk,
  input  logic        rst,
  sprfb_in_if.sink    in_ch,
  sprfb_out_if.source out_ch
);

  logic                 s1_valid;
  sprfb_pkg::item_t     s1_item;
  logic                 out_valid;
  sprfb_pkg::result_t   out_res;

  logic                 advance;
  logic                 fire;
  sprfb_pkg::row_word_t rd_row;
  sprfb_pkg::row_word_t row_next;
  logic                 row_we;
  sprfb_pkg::result_t   res;

  assign advance     = !out_valid || out_ch.ready;
  assign in_ch.ready = !s1_valid || advance;
  assign fire        = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_valid <= in_ch.valid;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_item.op          <= sprfb_pkg::op_t'(in_ch.op);
      s1_item.col_x       <= in_ch.col_x;
      s1_item.row_y       <= in_ch.row_y;
      s1_item.sprite_bits <= in_ch.sprite_bits;
    end
    if (fire) begin
      out_res <= res;
    end
  end

  sprfb_frame_store u_store (
    .clk    (clk),
    .rst    (rst),
    .idx    (s1_item.row_y[sprfb_pkg::ROW_IDX_W-1:0]),
    .rd_row (rd_row),
    .we     (fire && row_we),
    .wr_row (row_next)
  );

  sprfb_row_unit u_row (
    .item     (s1_item),
    .row      (rd_row),
    .row_next (row_next),
    .we       (row_we),
    .res      (res)
  );

  assign out_ch.valid       = out_valid;
  assign out_ch.collision   = out_res.collision;
  assign out_ch.pixels_read = out_res.pixels_read;

endmodule
